FILE: sv/h_pattern_shifter_gear_decoder_assert.svh
// ----------------------------------------------------------------------------
// H-pattern shifter gear decoder: assertion macros
// Shared property wrappers, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef H_PATTERN_SHIFTER_GEAR_DECODER_ASSERT_SVH
`define H_PATTERN_SHIFTER_GEAR_DECODER_ASSERT_SVH

// Same-cycle implication.
`define HPSGD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpsgd: same-cycle check failed");

// Next-cycle implication.
`define HPSGD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpsgd: next-cycle check failed");

`endif

FILE: sv/hpsgd_pkg.sv
// ----------------------------------------------------------------------------
// H-pattern shifter gear decoder package
// Types, register indexes, reset values and gear codes shared by the RTL.
// ----------------------------------------------------------------------------
package hpsgd_pkg;

	localparam int AxisW      = 10;
	localparam int PeriodW    = 16;
	localparam int TimeW      = 32;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 16;
	localparam int InTdataW   = 56;
	localparam int OutTdataW  = 8;

	typedef logic [AxisW-1:0]   axis_t;
	typedef logic [PeriodW-1:0] period_t;
	typedef logic [TimeW-1:0]   time_ms_t;
	typedef logic signed [3:0]  gear_t;

	// Presence detector phases, also the link_state code on the output.
	typedef enum logic [1:0] {
		PH_CONNECTED    = 2'd0,
		PH_PLUGIN       = 2'd1,
		PH_UNPLUG       = 2'd2,
		PH_DISCONNECTED = 2'd3
	} link_phase_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_ODD_ENGAGE    = 3'd0,
		REG_ODD_RELEASE   = 3'd1,
		REG_EVEN_ENGAGE   = 3'd2,
		REG_EVEN_RELEASE  = 3'd3,
		REG_LEFT_EDGE     = 3'd4,
		REG_RIGHT_EDGE    = 3'd5,
		REG_STABLE_PERIOD = 3'd6
	} cfg_reg_t;

	// Thresholds that the gear decoder needs.
	typedef struct packed {
		axis_t odd_engage;
		axis_t odd_release;
		axis_t even_engage;
		axis_t even_release;
		axis_t left_edge;
		axis_t right_edge;
	} gear_cfg_t;

	localparam axis_t   RST_ODD_ENGAGE    = 10'd869;
	localparam axis_t   RST_ODD_RELEASE   = 10'd767;
	localparam axis_t   RST_EVEN_ENGAGE   = 10'd153;
	localparam axis_t   RST_EVEN_RELEASE  = 10'd255;
	localparam axis_t   RST_LEFT_EDGE     = 10'd204;
	localparam axis_t   RST_RIGHT_EDGE    = 10'd818;
	localparam period_t RST_STABLE_PERIOD = 16'd250;

	localparam gear_t GEAR_REVERSE = -4'sd1;
	localparam gear_t GEAR_NEUTRAL = 4'sd0;
	localparam gear_t GEAR_FIVE    = 4'sd5;
	localparam gear_t GEAR_SIX     = 4'sd6;
	localparam gear_t ROW_ODD      = 4'sd1;
	localparam gear_t ROW_EVEN     = 4'sd2;
	localparam gear_t GATE_MID     = 4'sd2;
	localparam gear_t GATE_RIGHT   = 4'sd4;

endpackage

FILE: sv/hpsgd_gear_dec.sv
// ----------------------------------------------------------------------------
// Gear decoder
// Maps stick position, reverse button and the held gear to the next gear.
// ----------------------------------------------------------------------------
module hpsgd_gear_dec (
	input  hpsgd_pkg::gear_cfg_t cfg,
	input  hpsgd_pkg::gear_t     prev_gear,
	input  hpsgd_pkg::axis_t     axis_x,
	input  hpsgd_pkg::axis_t     axis_y,
	input  logic                 reverse_pressed,
	output hpsgd_pkg::gear_t     gear
);

	logic             was_odd;
	logic             was_even;
	logic             keep;
	hpsgd_pkg::gear_t row_gear;
	hpsgd_pkg::gear_t gated_gear;
	hpsgd_pkg::gear_t rule_gear;

	always_comb begin
		// Reverse counts as an even-row gear for release hysteresis.
		was_odd  = (prev_gear != hpsgd_pkg::GEAR_REVERSE) && prev_gear[0];
		was_even = !was_odd && (prev_gear != hpsgd_pkg::GEAR_NEUTRAL);
		keep     = (was_odd && (axis_y > cfg.odd_release)) ||
		           (was_even && (axis_y < cfg.even_release));

		row_gear = hpsgd_pkg::GEAR_NEUTRAL;
		if (axis_y > cfg.odd_engage) begin
			row_gear = hpsgd_pkg::ROW_ODD;
		end else if (axis_y < cfg.even_engage) begin
			row_gear = hpsgd_pkg::ROW_EVEN;
		end

		gated_gear = row_gear;
		if (row_gear != hpsgd_pkg::GEAR_NEUTRAL) begin
			if (axis_x > cfg.right_edge) begin
				gated_gear = row_gear + hpsgd_pkg::GATE_RIGHT;
			end else if (axis_x >= cfg.left_edge) begin
				gated_gear = row_gear + hpsgd_pkg::GATE_MID;
			end
		end

		// Reverse rules: button blocks fifth, sixth turns into reverse.
		rule_gear = gated_gear;
		if (reverse_pressed && (gated_gear == hpsgd_pkg::GEAR_FIVE)) begin
			rule_gear = hpsgd_pkg::GEAR_NEUTRAL;
		end else if ((reverse_pressed || (prev_gear == hpsgd_pkg::GEAR_REVERSE)) &&
		             (gated_gear == hpsgd_pkg::GEAR_SIX)) begin
			rule_gear = hpsgd_pkg::GEAR_REVERSE;
		end

		gear = keep ? prev_gear : rule_gear;
	end

endmodule

FILE: sv/h_pattern_shifter_gear_decoder.sv
// ----------------------------------------------------------------------------
// H-pattern shifter gear decoder, top level
// Presence detector plus gear decode, one result word per poll word.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  poll word (level, X, Y, rev, ms)
// m_axis    out        m_axis_tvalid/m_axis_tready  result word (gear, changed, link)
// cfg       in         cfg_valid/cfg_ready          register index + write data
//
// Cycles: one poll word per clock sustained while m_axis_tready is high; a word
// is held in the input register, and its result is registered in the output
// register as it advances. The link/gear state update is the loop that sets the rate.
// Reset: link connected, level high, edge time 0, gear neutral, default thresholds.
// Stalls: cfg_ready stays high; with a result pending and m_axis_tready low,
// the input register holds and s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
`include "h_pattern_shifter_gear_decoder_assert.svh"

module h_pattern_shifter_gear_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hpsgd_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [hpsgd_pkg::CfgDataW-1:0]       cfg_data,
	// poll words
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [0] detect_level, [10:1] axis_x, [20:11] axis_y, [21] reverse_pressed,
	// [53:22] now_ms, [55:54] zero
	input  logic [hpsgd_pkg::InTdataW-1:0]       s_axis_tdata,
	// result words
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [3:0] gear (signed), [4] gear_changed, [6:5] link_state, [7] zero
	output logic [hpsgd_pkg::OutTdataW-1:0]      m_axis_tdata
);

	// Configuration registers.
	hpsgd_pkg::gear_cfg_t        gear_cfg_q;
	hpsgd_pkg::period_t          stable_period_q;

	// Input register.
	logic                        valid_s1;
	logic                        detect_s1;
	hpsgd_pkg::axis_t            axis_x_s1;
	hpsgd_pkg::axis_t            axis_y_s1;
	logic                        reverse_s1;
	hpsgd_pkg::time_ms_t         now_s1;

	// Detector and gear state.
	hpsgd_pkg::link_phase_t      phase_q;
	hpsgd_pkg::link_phase_t      phase_d;
	logic                        last_level_q;
	logic                        last_level_d;
	hpsgd_pkg::time_ms_t         edge_time_q;
	hpsgd_pkg::time_ms_t         edge_time_d;
	hpsgd_pkg::gear_t            held_gear_q;

	// Result register.
	logic                        out_valid_q;
	hpsgd_pkg::gear_t            out_gear_q;
	logic                        out_changed_q;
	hpsgd_pkg::link_phase_t      out_link_q;

	hpsgd_pkg::gear_t            dec_gear;
	hpsgd_pkg::gear_t            res_gear;
	logic                        res_changed;
	hpsgd_pkg::time_ms_t         elapsed;
	logic                        period_met;
	logic                        s_accept;
	logic                        advance;

	// Result word classification for the checks.
	logic                        out_unplug;
	logic                        out_holding;
	logic                        out_gear_ok;

	// ------------------------------------------------------------------
	// Handshake: the input register moves into the result register when
	// the result register is empty or being drained this cycle.
	// ------------------------------------------------------------------
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the poll word; no reset on payload.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			detect_s1  <= s_axis_tdata[0];
			axis_x_s1  <= s_axis_tdata[10:1];
			axis_y_s1  <= s_axis_tdata[20:11];
			reverse_s1 <= s_axis_tdata[21];
			now_s1     <= s_axis_tdata[53:22];
		end
	end

	// ------------------------------------------------------------------
	// Configuration writes; indexes past the list are dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_cfg_q.odd_engage   <= hpsgd_pkg::RST_ODD_ENGAGE;
			gear_cfg_q.odd_release  <= hpsgd_pkg::RST_ODD_RELEASE;
			gear_cfg_q.even_engage  <= hpsgd_pkg::RST_EVEN_ENGAGE;
			gear_cfg_q.even_release <= hpsgd_pkg::RST_EVEN_RELEASE;
			gear_cfg_q.left_edge    <= hpsgd_pkg::RST_LEFT_EDGE;
			gear_cfg_q.right_edge   <= hpsgd_pkg::RST_RIGHT_EDGE;
			stable_period_q         <= hpsgd_pkg::RST_STABLE_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hpsgd_pkg::REG_ODD_ENGAGE: begin
					gear_cfg_q.odd_engage <= cfg_data[hpsgd_pkg::AxisW-1:0];
				end
				hpsgd_pkg::REG_ODD_RELEASE: begin
					gear_cfg_q.odd_release <= cfg_data[hpsgd_pkg::AxisW-1:0];
				end
				hpsgd_pkg::REG_EVEN_ENGAGE: begin
					gear_cfg_q.even_engage <= cfg_data[hpsgd_pkg::AxisW-1:0];
				end
				hpsgd_pkg::REG_EVEN_RELEASE: begin
					gear_cfg_q.even_release <= cfg_data[hpsgd_pkg::AxisW-1:0];
				end
				hpsgd_pkg::REG_LEFT_EDGE: begin
					gear_cfg_q.left_edge <= cfg_data[hpsgd_pkg::AxisW-1:0];
				end
				hpsgd_pkg::REG_RIGHT_EDGE: begin
					gear_cfg_q.right_edge <= cfg_data[hpsgd_pkg::AxisW-1:0];
				end
				hpsgd_pkg::REG_STABLE_PERIOD: begin
					stable_period_q <= cfg_data[hpsgd_pkg::PeriodW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Presence detector, next state.
	// Elapsed time wraps modulo 2^32, matching the free-running timestamp.
	// ------------------------------------------------------------------
	assign elapsed    = now_s1 - edge_time_q;
	assign period_met = elapsed >= {{(hpsgd_pkg::TimeW-hpsgd_pkg::PeriodW){1'b0}},
	                                stable_period_q};

	always_comb begin
		phase_d      = phase_q;
		last_level_d = last_level_q;
		edge_time_d  = edge_time_q;
		if (detect_s1 && (phase_q == hpsgd_pkg::PH_CONNECTED)) begin
			// Connected and present: nothing to do.
		end else if (detect_s1 != last_level_q) begin
			// Edge on the detect pin: restart the stability timer.
			last_level_d = detect_s1;
			edge_time_d  = now_s1;
			phase_d      = detect_s1 ? hpsgd_pkg::PH_PLUGIN : hpsgd_pkg::PH_UNPLUG;
		end else if (detect_s1) begin
			if (period_met) begin
				phase_d = hpsgd_pkg::PH_CONNECTED;
			end
		end else if (phase_q == hpsgd_pkg::PH_UNPLUG) begin
			phase_d = hpsgd_pkg::PH_DISCONNECTED;
		end
	end

	// ------------------------------------------------------------------
	// Gear decode, used only when the new phase is connected.
	// ------------------------------------------------------------------
	hpsgd_gear_dec u_gear_dec (
		.cfg             (gear_cfg_q),
		.prev_gear       (held_gear_q),
		.axis_x          (axis_x_s1),
		.axis_y          (axis_y_s1),
		.reverse_pressed (reverse_s1),
		.gear            (dec_gear)
	);

	// Result by phase: decode when connected, force neutral on unplug,
	// hold the gear otherwise.
	always_comb begin
		res_gear    = held_gear_q;
		res_changed = 1'b0;
		case (phase_d)
			hpsgd_pkg::PH_CONNECTED: begin
				res_gear    = dec_gear;
				res_changed = (dec_gear != held_gear_q);
			end
			hpsgd_pkg::PH_UNPLUG: begin
				res_gear    = hpsgd_pkg::GEAR_NEUTRAL;
				res_changed = (held_gear_q != hpsgd_pkg::GEAR_NEUTRAL);
			end
			default: begin
			end
		endcase
	end

	// Commit state as the word moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= hpsgd_pkg::PH_CONNECTED;
			last_level_q <= 1'b1;
			edge_time_q  <= '0;
			held_gear_q  <= hpsgd_pkg::GEAR_NEUTRAL;
		end else if (advance) begin
			phase_q      <= phase_d;
			last_level_q <= last_level_d;
			edge_time_q  <= edge_time_d;
			held_gear_q  <= res_gear;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_gear_q    <= res_gear;
			out_changed_q <= res_changed;
			out_link_q    <= phase_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_link_q, out_changed_q, out_gear_q};

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	assign out_unplug  = out_valid_q && (out_link_q == hpsgd_pkg::PH_UNPLUG);
	assign out_holding = out_valid_q && ((out_link_q == hpsgd_pkg::PH_PLUGIN) ||
	                     (out_link_q == hpsgd_pkg::PH_DISCONNECTED));
	assign out_gear_ok = (out_gear_q >= hpsgd_pkg::GEAR_REVERSE) &&
	                     (out_gear_q <= hpsgd_pkg::GEAR_SIX);

	// A shown result always matches the held gear.
	`HPSGD_ASSERT_NOW(a_out_matches_held, out_valid_q, out_gear_q == held_gear_q)
	// Connected implies the last seen detect level was high.
	`HPSGD_ASSERT_NOW(a_connected_level, phase_q == hpsgd_pkg::PH_CONNECTED, last_level_q)
	// An unplug result reports neutral.
	`HPSGD_ASSERT_NOW(a_unplug_neutral, out_unplug, out_gear_q == hpsgd_pkg::GEAR_NEUTRAL)
	// Plugging in or disconnected never reports a change.
	`HPSGD_ASSERT_NOW(a_hold_no_change, out_holding, !out_changed_q)
	// Gear stays within reverse to sixth.
	`HPSGD_ASSERT_NOW(a_gear_range, out_valid_q, out_gear_ok)
	// State moves only when a word advances.
	`HPSGD_ASSERT_NEXT(a_state_hold, !advance, $stable(held_gear_q) && $stable(phase_q))

endmodule

FILE: tb/sv/h_pattern_shifter_gear_decoder_tb.sv
// ----------------------------------------------------------------------------
// H-pattern shifter gear decoder testbench
// Streams poll words through the decoder and checks every result word against
// a cycle-free model of the presence detector and gear decode, under several
// threshold settings, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module h_pattern_shifter_gear_decoder_tb;
	import hpsgd_pkg::*;

	// Poll fields, highest bit first when packed into s_axis_tdata.
	typedef struct packed {
		time_ms_t now;
		logic     rev;
		axis_t    y;
		axis_t    x;
		logic     level;
	} poll_t;

	// Result fields, highest bit first when packed into m_axis_tdata.
	typedef struct packed {
		link_phase_t link;
		logic        changed;
		gear_t       gear;
	} gear_report_t;

	localparam int PollW   = $bits(poll_t);
	localparam int ReportW = $bits(gear_report_t);
	localparam int QuietLimit = 3000;
	localparam int LongHold   = 300;
	localparam int BatchPolls = 255;
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

	typedef enum int {
		PACE_SEND_LIGHT,
		PACE_RECV_LIGHT,
		PACE_FREE
	} pace_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [InTdataW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OutTdataW-1:0] m_axis_tdata;

	h_pattern_shifter_gear_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Words waiting to be offered, and reports owed by the block.
	poll_t        poll_backlog[$];
	gear_report_t gear_reports_due[$];

	// Tracker copy of the thresholds and of the detector/gear state.
	gear_cfg_t   thr;
	period_t     settle_ms;
	link_phase_t det_phase;
	logic        det_level;
	time_ms_t    det_edge_ms;
	gear_t       cur_gear;

	// Stimulus generator state.
	time_ms_t gen_ms;
	int       down_left;
	pace_t    pace = PACE_SEND_LIGHT;
	int       hold_requests = 0;

	// Bookkeeping.
	int fail_count = 0;
	int polls_taken = 0;
	int reports_checked = 0;
	int cfg_writes = 0;
	int unplug_events = 0;
	int input_stall_cycles = 0;
	logic [7:0] gears_reached = '0;

	// ------------------------------------------------------------------------
	// Tracker of the presence detector and gear decode
	// ------------------------------------------------------------------------
	task reset_tracker();
		thr.odd_engage   = RST_ODD_ENGAGE;
		thr.odd_release  = RST_ODD_RELEASE;
		thr.even_engage  = RST_EVEN_ENGAGE;
		thr.even_release = RST_EVEN_RELEASE;
		thr.left_edge    = RST_LEFT_EDGE;
		thr.right_edge   = RST_RIGHT_EDGE;
		settle_ms        = RST_STABLE_PERIOD;
		det_phase        = PH_CONNECTED;
		det_level        = 1'b1;
		det_edge_ms      = '0;
		cur_gear         = GEAR_NEUTRAL;
	endtask

	// Mirror one register write: thresholds keep their low ten bits,
	// unknown indexes change nothing.
	task track_reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		case (idx)
			REG_ODD_ENGAGE:    thr.odd_engage   = data[AxisW-1:0];
			REG_ODD_RELEASE:   thr.odd_release  = data[AxisW-1:0];
			REG_EVEN_ENGAGE:   thr.even_engage  = data[AxisW-1:0];
			REG_EVEN_RELEASE:  thr.even_release = data[AxisW-1:0];
			REG_LEFT_EDGE:     thr.left_edge    = data[AxisW-1:0];
			REG_RIGHT_EDGE:    thr.right_edge   = data[AxisW-1:0];
			REG_STABLE_PERIOD: settle_ms        = data;
			default: ;
		endcase
	endtask

	// Advance the detector by one poll, then decode or hold the gear.
	function automatic gear_report_t decode_poll(poll_t p);
		gear_t        prev;
		gear_t        g;
		logic         was_odd;
		logic         was_even;
		gear_report_t r;

		prev = cur_gear;
		r.changed = 1'b0;

		// A connected stick with the level high skips the detector entirely.
		if (!(p.level && det_phase == PH_CONNECTED)) begin
			if (p.level != det_level) begin
				det_level   = p.level;
				det_edge_ms = p.now;
				det_phase   = p.level ? PH_PLUGIN : PH_UNPLUG;
				if (!p.level)
					unplug_events++;
			end else if (p.level) begin
				// Elapsed time is taken modulo 2^32, so a wrapped clock still counts.
				if (time_ms_t'(p.now - det_edge_ms) >= time_ms_t'(settle_ms))
					det_phase = PH_CONNECTED;
			end else if (det_phase == PH_UNPLUG) begin
				det_phase = PH_DISCONNECTED;
			end
		end

		if (det_phase == PH_CONNECTED) begin
			was_odd  = (prev != GEAR_REVERSE) && prev[0];
			was_even = !was_odd && (prev != GEAR_NEUTRAL);
			if ((was_odd && p.y > thr.odd_release) ||
					(was_even && p.y < thr.even_release)) begin
				g = prev;
			end else begin
				g = GEAR_NEUTRAL;
				if (p.y > thr.odd_engage)
					g = ROW_ODD;
				else if (p.y < thr.even_engage)
					g = ROW_EVEN;
				if (g != GEAR_NEUTRAL) begin
					if (p.x > thr.right_edge)
						g = g + GATE_RIGHT;
					else if (p.x >= thr.left_edge)
						g = g + GATE_MID;
					// Reverse rules come last: fifth drops out, sixth turns to reverse.
					if (p.rev && g == GEAR_FIVE)
						g = GEAR_NEUTRAL;
					else if ((p.rev || prev == GEAR_REVERSE) && g == GEAR_SIX)
						g = GEAR_REVERSE;
				end
			end
			r.changed = (g != prev);
			cur_gear = g;
			gears_reached[int'(g) + 1] = 1'b1;
		end else if (det_phase == PH_UNPLUG) begin
			r.changed = (prev != GEAR_NEUTRAL);
			cur_gear = GEAR_NEUTRAL;
		end

		r.gear = cur_gear;
		r.link = det_phase;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task push_poll(input logic level, input axis_t x, input axis_t y, input logic rev,
			input time_ms_t dt);
		gen_ms = gen_ms + dt;
		poll_backlog.push_back(poll_t'{now: gen_ms, rev: rev, y: y, x: x, level: level});
	endtask

	// Land within two counts of a threshold, clamped to the axis range.
	function automatic axis_t near_level(axis_t lvl);
		int v;
		v = int'(lvl) + int'($urandom_range(0, 4)) - 2;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return axis_t'(v);
	endfunction

	function automatic axis_t pick_axis(axis_t a, axis_t b, axis_t c, axis_t d);
		case ($urandom_range(0, 9))
			0: return near_level(a);
			1: return near_level(b);
			2: return near_level(c);
			3: return near_level(d);
			4: return $urandom_range(0, 1) ? axis_t'(1023) : axis_t'(0);
			default: return axis_t'($urandom_range(0, 1023));
		endcase
	endfunction

	// Random register value: ten-bit thresholds, short stable period.
	function automatic logic [CfgDataW-1:0] rand_cfg(int hi);
		return CfgDataW'($urandom_range(0, hi));
	endfunction

	// Mostly a plugged stick polled at a steady pace with short unplugs and
	// single-poll glitches; a few raw words with any timestamp at all.
	task queue_random_polls(input int n);
		int       i;
		logic     lvl;
		time_ms_t dt;

		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				poll_backlog.push_back(poll_t'{now: $urandom,
					rev: 1'($urandom_range(0, 1)),
					y: axis_t'($urandom_range(0, 1023)),
					x: axis_t'($urandom_range(0, 1023)),
					level: 1'($urandom_range(0, 1))});
			end else begin
				if (down_left > 0) begin
					down_left--;
					lvl = 1'b0;
				end else if ($urandom_range(0, 99) < 3) begin
					down_left = $urandom_range(0, 7);
					lvl = 1'b0;
				end else begin
					lvl = 1'b1;
				end
				if ($urandom_range(0, 99) < 4)
					dt = $urandom_range(0, 70000);
				else
					dt = $urandom_range(0, 40);
				push_poll(lvl,
					pick_axis(thr.left_edge, thr.right_edge, thr.left_edge, thr.right_edge),
					pick_axis(thr.odd_engage, thr.odd_release, thr.even_engage,
						thr.even_release),
					$urandom_range(0, 3) == 0, dt);
			end
		end
	endtask

	task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		track_reg_write(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task write_set(input logic [CfgDataW-1:0] odd_e, input logic [CfgDataW-1:0] odd_r,
			input logic [CfgDataW-1:0] even_e, input logic [CfgDataW-1:0] even_r,
			input logic [CfgDataW-1:0] left, input logic [CfgDataW-1:0] right,
			input logic [CfgDataW-1:0] period);
		write_reg(REG_ODD_ENGAGE, odd_e);
		write_reg(REG_ODD_RELEASE, odd_r);
		write_reg(REG_EVEN_ENGAGE, even_e);
		write_reg(REG_EVEN_RELEASE, even_r);
		write_reg(REG_LEFT_EDGE, left);
		write_reg(REG_RIGHT_EDGE, right);
		write_reg(REG_STABLE_PERIOD, period);
	endtask

	// Hold off until every queued word went in and every report came back,
	// then let the two-stage pipe settle.
	task wait_idle();
		do
			@(posedge clk);
		while (poll_backlog.size() != 0 || s_axis_tvalid || gear_reports_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic int send_idle_pct(pace_t p);
		case (p)
			PACE_SEND_LIGHT: return 15;
			PACE_RECV_LIGHT: return 71;
			default:         return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct(pace_t p);
		case (p)
			PACE_SEND_LIGHT: return 71;
			PACE_RECV_LIGHT: return 15;
			default:         return 0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer backlog words, predict each one as it is taken
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				gear_reports_due.push_back(decode_poll(poll_t'(s_axis_tdata[PollW-1:0])));
				polls_taken++;
			end else if (s_axis_tvalid) begin
				input_stall_cycles++;
			end
			// Hold a word that is still waiting; otherwise advance or go idle.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (poll_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(pace)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{(InTdataW-PollW){1'b0}}, poll_backlog.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check result words, drive tready with random and long stalls
	// ------------------------------------------------------------------------
	int hold_served = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		gear_report_t got;
		gear_report_t want;

		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = gear_report_t'(m_axis_tdata[ReportW-1:0]);
				if (gear_reports_due.size() == 0) begin
					$error("unexpected result word: gear %0d changed %0d link %0d",
						got.gear, got.changed, got.link);
					fail_count++;
				end else begin
					want = gear_reports_due.pop_front();
					reports_checked++;
					if (got.gear !== want.gear) begin
						$error("gear: expected %0d, got %0d", want.gear, got.gear);
						fail_count++;
					end
					if (got.changed !== want.changed) begin
						$error("gear_changed: expected %0d, got %0d", want.changed, got.changed);
						fail_count++;
					end
					if (got.link !== want.link) begin
						$error("link_state: expected %0d, got %0d", want.link, got.link);
						fail_count++;
					end
				end
			end
			// A pending long hold takes priority over the random pattern.
			if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct(pace));
			end
		end
	end

	// Drop the run if no handshake of any kind happens for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("watchdog: no handshake for %0d cycles", QuietLimit);
				$display("[h_pattern_shifter_gear_decoder] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of phases
	// ------------------------------------------------------------------------
	initial begin
		reset_tracker();
		gen_ms = '0;
		down_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk with reset thresholds: every gate and row, holds and
		// releases at their exact levels, the reverse rules, unplug with and
		// without a gear, plug-in timing and a timestamp wrap.
		push_poll(1'b1, 10'd0,    10'd1023, 1'b0, 1);
		push_poll(1'b1, 10'd1023, 10'd768,  1'b1, 1);
		push_poll(1'b1, 10'd500,  10'd767,  1'b0, 1);
		push_poll(1'b1, 10'd203,  10'd0,    1'b0, 1);
		push_poll(1'b1, 10'd1023, 10'd254,  1'b1, 1);
		push_poll(1'b1, 10'd204,  10'd255,  1'b0, 1);
		push_poll(1'b1, 10'd204,  10'd870,  1'b0, 1);
		push_poll(1'b1, 10'd818,  10'd512,  1'b0, 1);
		push_poll(1'b1, 10'd818,  10'd152,  1'b0, 1);
		push_poll(1'b1, 10'd819,  10'd512,  1'b0, 1);
		push_poll(1'b1, 10'd819,  10'd1023, 1'b0, 1);
		push_poll(1'b1, 10'd819,  10'd512,  1'b0, 1);
		push_poll(1'b1, 10'd1023, 10'd1023, 1'b1, 1);
		push_poll(1'b1, 10'd1023, 10'd0,    1'b0, 1);
		push_poll(1'b1, 10'd1023, 10'd512,  1'b0, 1);
		push_poll(1'b1, 10'd1023, 10'd0,    1'b1, 1);
		push_poll(1'b1, 10'd0,    10'd100,  1'b0, 1);
		push_poll(1'b0, 10'd0,    10'd512,  1'b0, 1);
		push_poll(1'b0, 10'd1023, 10'd1023, 1'b0, 1);
		push_poll(1'b1, 10'd1023, 10'd1023, 1'b0, 1);
		push_poll(1'b1, 10'd0,    10'd1023, 1'b0, 249);
		push_poll(1'b1, 10'd0,    10'd1023, 1'b0, 1);
		push_poll(1'b1, 10'd0,    10'd512,  1'b0, 1);
		push_poll(1'b0, 10'd0,    10'd512,  1'b0, 1);
		push_poll(1'b1, 10'd0,    10'd512,  1'b0, 1);
		gen_ms = 32'hFFFF_FF00;
		push_poll(1'b0, 10'd0,    10'd512,  1'b0, 0);
		push_poll(1'b1, 10'd0,    10'd512,  1'b0, 32'h10);
		push_poll(1'b1, 10'd0,    10'd1023, 1'b0, 32'hEF);
		push_poll(1'b1, 10'd0,    10'd1023, 1'b0, 10);
		push_poll(1'b1, 10'd0,    10'd1023, 1'b0, 1);
		wait_idle();

		// Sender idles lightly, receiver heavily. An even engage level above the even
		// release level opens the reverse-then-sixth path.
		pace = PACE_SEND_LIGHT;
		write_set(16'd900, 16'd700, 16'd300, 16'd200, 16'd100, 16'd900, 16'd100);
		queue_random_polls(BatchPolls);
		wait_idle();
		write_set(rand_cfg(1023), rand_cfg(1023), rand_cfg(1023), rand_cfg(1023),
			rand_cfg(1023), rand_cfg(1023), rand_cfg(400));
		queue_random_polls(BatchPolls);
		wait_idle();

		// Roles swap. Extreme settings, an ignored index and masked data.
		pace = PACE_RECV_LIGHT;
		write_set(16'd0, 16'd0, 16'd1023, 16'd1023, 16'd0, 16'd1023, 16'd0);
		write_reg(REG_UNUSED, 16'h1234);
		queue_random_polls(BatchPolls);
		wait_idle();
		write_set(16'hFFFF, 16'h03FF, 16'hFC00, 16'h0000, 16'hFFFF, 16'h0400, 16'hFFFF);
		queue_random_polls(BatchPolls);
		wait_idle();

		// No idling; open with a long receiver hold so the pipe fills and
		// the input backs up while the sender keeps offering.
		pace = PACE_FREE;
		write_set(CfgDataW'(RST_ODD_ENGAGE), CfgDataW'(RST_ODD_RELEASE),
			CfgDataW'(RST_EVEN_ENGAGE), CfgDataW'(RST_EVEN_RELEASE),
			CfgDataW'(RST_LEFT_EDGE), CfgDataW'(RST_RIGHT_EDGE), RST_STABLE_PERIOD);
		hold_requests++;
		queue_random_polls(BatchPolls);
		wait_idle();
		write_set(rand_cfg(1023), rand_cfg(1023), rand_cfg(1023), rand_cfg(1023),
			rand_cfg(1023), rand_cfg(1023), rand_cfg(400));
		queue_random_polls(BatchPolls);
		wait_idle();

		// Give any stray word time to show up before the verdict.
		repeat (6) @(posedge clk);

		$display("Checked %0d result words for %0d polls across %0d register writes;",
			reports_checked, polls_taken, cfg_writes);
		$display("%0d unplug events, %0d backpressured cycles, gears -1..6 reached: %08b",
			unplug_events, input_stall_cycles, gears_reached);
		if (fail_count == 0)
			$display("[h_pattern_shifter_gear_decoder] OK");
		else
			$display("[h_pattern_shifter_gear_decoder] ERROR");
		$finish;
	end

endmodule
